/* rtl/mkres_pkg.sv */
`timescale 1ns / 1ps
package mkres_pkg;
  localparam int MaxRecords = 64;
  localparam int NameBytes  = 128;
  localparam int IdxW  = $clog2(MaxRecords);
  localparam int CntW  = $clog2(MaxRecords + 1);
  localparam int PosW  = $clog2(NameBytes);
  localparam int LenW  = $clog2(NameBytes + 1);
  localparam int AddrW = IdxW + PosW;

  localparam logic [1:0] OpStart = 2'd0;
  localparam logic [1:0] OpFirst = 2'd1;
  localparam logic [1:0] OpLast  = 2'd2;
  localparam logic [1:0] OpSort  = 2'd3;

  localparam logic [1:0] CritNone  = 2'd0;
  localparam logic [1:0] CritLast  = 2'd1;
  localparam logic [1:0] CritFirst = 2'd2;
  localparam logic [1:0] CritAge   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;       // accept an input word
    logic set_ij;     // i <= 0, j <= 1
    logic next_j;     // advance pair
    logic rd_pair;    // read order entries i, j
    logic rd_meta;    // read ages and lengths of a and b
    logic cmp_clr;    // restart byte compare, select name
    logic cmp_sel;    // 0 last name, 1 first name
    logic rd_byte;    // read bytes at position k
    logic cmp_step;   // compare bytes, advance k
    logic swap_wr_i;  // write order[i] <= b
    logic swap_wr_j;  // write order[j] <= a
    logic emit_clr;   // e <= 0
    logic emit_rd;    // read order[e]
    logic emit_age;   // read age of order[e]
    logic emit_next;  // e++
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic empty;       // no records loaded
    logic one_left;    // single record -> no pairs
    logic pair_done;   // j was last, i would reach end
    logic ages_eq;
    logic age_swap;    // age a < age b
    logic cmp_done;    // byte compare resolved
    logic [1:0] cmp_res; // 0 eq, 1 lt, 2 gt
    logic emit_last;
  } stat_t;

  localparam logic [1:0] CmpEq = 2'd0;
  localparam logic [1:0] CmpLt = 2'd1;
  localparam logic [1:0] CmpGt = 2'd2;
endpackage

/* rtl/mkres_ram.sv */
`timescale 1ns / 1ps
module mkres_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end
  assign rdata_o = rdata_q;
endmodule

/* rtl/mkres_datapath.sv */
`timescale 1ns / 1ps
module mkres_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mkres_pkg::ctrl_t    ctrl_i,
  output mkres_pkg::stat_t    stat_o,
  input  logic [1:0]          op_i,
  input  logic [7:0]          name_byte_i,
  input  logic [7:0]          age_i,
  output logic [5:0]          record_index_o,
  output logic [7:0]          record_age_o,
  output logic                overflowed_o
);
  import mkres_pkg::*;

  logic [CntW-1:0] count_q, count_d;
  logic            open_q, open_d;
  logic            ovf_q, ovf_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, e_q, e_d;
  logic [PosW-1:0] k_q, k_d;
  logic [LenW-1:0] fl_q, fl_d, ll_q, ll_d;   // open record lengths
  logic [IdxW-1:0] a_q, b_q;
  logic [LenW-1:0] la_q, lb_q;
  logic [1:0]      res_q, res_d;
  logic            done_q, done_d;
  logic            sel_q;
  logic            phase_q;                  // byte read alternates a then b
  logic [7:0]      ca_q;

  logic [IdxW-1:0] cur;
  assign cur = IdxW'(count_q - CntW'(1));

  // load decode
  logic st_ok, fb_ok, lb_ok;
  assign st_ok = ctrl_i.load && op_i == OpStart && count_q < CntW'(MaxRecords);
  assign fb_ok = ctrl_i.load && op_i == OpFirst && name_byte_i != 8'd0 && open_q &&
                 count_q != '0 && fl_q < LenW'(NameBytes);
  assign lb_ok = ctrl_i.load && op_i == OpLast && name_byte_i != 8'd0 && open_q &&
                 count_q != '0 && ll_q < LenW'(NameBytes);

  // order table
  logic            ord_we, ord_re;
  logic [IdxW-1:0] ord_wa, ord_ra, ord_wd, ord_rd;
  // ages and lengths share one read address
  logic            meta_re;
  logic [IdxW-1:0] meta_ra;
  logic [7:0]      age_rd;
  logic [LenW-1:0] fln_rd, lln_rd;
  // name bytes
  logic            nm_re;
  logic [AddrW-1:0] nm_ra;
  logic [7:0]      fn_rd, ln_rd;

  // read step bookkeeping: rd_pair reads i this cycle, j the next via phase
  logic pr_q, pb_q, mr_q, mb_q;

  always_comb begin
    ord_we = st_ok || ctrl_i.swap_wr_i || ctrl_i.swap_wr_j;
    ord_wa = st_ok ? count_q[IdxW-1:0] : (ctrl_i.swap_wr_i ? i_q : j_q);
    ord_wd = st_ok ? count_q[IdxW-1:0] : (ctrl_i.swap_wr_i ? b_q : a_q);
    ord_re = ctrl_i.rd_pair || ctrl_i.emit_rd;
    ord_ra = ctrl_i.emit_rd ? e_q : (phase_q ? j_q : i_q);
    meta_re = ctrl_i.rd_meta || ctrl_i.emit_age;
    meta_ra = ctrl_i.emit_age ? ord_rd : (phase_q ? b_q : a_q);
    nm_re = ctrl_i.rd_byte;
    nm_ra = {(phase_q ? b_q : a_q), k_q};
  end

  mkres_ram #(.Width(IdxW), .Depth(MaxRecords)) u_ord (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd),
    .re_i(ord_re), .raddr_i(ord_ra), .rdata_o(ord_rd));
  mkres_ram #(.Width(8), .Depth(MaxRecords)) u_age (
    .clk_i, .we_i(st_ok), .waddr_i(count_q[IdxW-1:0]), .wdata_i(age_i),
    .re_i(meta_re), .raddr_i(meta_ra), .rdata_o(age_rd));
  // lengths are written at start (zero) and on every appended byte
  mkres_ram #(.Width(LenW), .Depth(MaxRecords)) u_fln (
    .clk_i, .we_i(st_ok || fb_ok), .waddr_i(st_ok ? count_q[IdxW-1:0] : cur),
    .wdata_i(st_ok ? '0 : fl_q + LenW'(1)),
    .re_i(meta_re), .raddr_i(meta_ra), .rdata_o(fln_rd));
  mkres_ram #(.Width(LenW), .Depth(MaxRecords)) u_lln (
    .clk_i, .we_i(st_ok || lb_ok), .waddr_i(st_ok ? count_q[IdxW-1:0] : cur),
    .wdata_i(st_ok ? '0 : ll_q + LenW'(1)),
    .re_i(meta_re), .raddr_i(meta_ra), .rdata_o(lln_rd));
  mkres_ram #(.Width(8), .Depth(MaxRecords * NameBytes)) u_fn (
    .clk_i, .we_i(fb_ok), .waddr_i({cur, fl_q[PosW-1:0]}), .wdata_i(name_byte_i),
    .re_i(nm_re), .raddr_i(nm_ra), .rdata_o(fn_rd));
  mkres_ram #(.Width(8), .Depth(MaxRecords * NameBytes)) u_ln (
    .clk_i, .we_i(lb_ok), .waddr_i({cur, ll_q[PosW-1:0]}), .wdata_i(name_byte_i),
    .re_i(nm_re), .raddr_i(nm_ra), .rdata_o(ln_rd));

  logic [7:0] age_a_q;
  logic [LenW-1:0] fa_q, fb_q, lla_q, llb_q;

  // names: byte of a, then byte of b on the next step
  logic [7:0]      cb;
  logic [LenW-1:0] la_sel, lb_sel, lmin;
  assign cb = sel_q ? fn_rd : ln_rd;
  always_comb begin
    // on restart the name select is only being loaded, take it from the command
    la_sel = ctrl_i.cmp_clr ? (ctrl_i.cmp_sel ? fa_q : lla_q) : la_q;
    lb_sel = ctrl_i.cmp_clr ? (ctrl_i.cmp_sel ? fb_q : llb_q) : lb_q;
    lmin = (la_sel < lb_sel) ? la_sel : lb_sel;
  end

  // state update
  always_comb begin
    count_d = count_q; open_d = open_q; ovf_d = ovf_q;
    fl_d = fl_q; ll_d = ll_q;
    i_d = i_q; j_d = j_q; e_d = e_q; k_d = k_q;
    res_d = res_q; done_d = done_q;
    if (ctrl_i.load) begin
      unique case (op_i)
        OpStart: begin
          if (st_ok) begin
            count_d = count_q + CntW'(1); open_d = 1'b1; fl_d = '0; ll_d = '0;
          end else begin
            ovf_d = 1'b1; open_d = 1'b0;
          end
        end
        OpFirst: begin
          if (fb_ok) fl_d = fl_q + LenW'(1);
          else if (name_byte_i != 8'd0) ovf_d = 1'b1;
        end
        OpLast: begin
          if (lb_ok) ll_d = ll_q + LenW'(1);
          else if (name_byte_i != 8'd0) ovf_d = 1'b1;
        end
        default: ;
      endcase
    end
    if (ctrl_i.set_ij) begin
      i_d = '0; j_d = IdxW'(1);
    end
    if (ctrl_i.next_j) begin
      if (CntW'(j_q) + CntW'(1) >= count_q) begin
        i_d = i_q + IdxW'(1); j_d = i_q + IdxW'(2);
      end else begin
        j_d = j_q + IdxW'(1);
      end
    end
    if (ctrl_i.cmp_clr) begin
      k_d = '0; done_d = 1'b0; res_d = CmpEq;
      if (lmin == '0) begin
        done_d = 1'b1;
        res_d = (la_sel == lb_sel) ? CmpEq : ((la_sel < lb_sel) ? CmpLt : CmpGt);
      end
    end
    if (ctrl_i.cmp_step && !phase_q) begin
      if (ca_q != cb) begin
        done_d = 1'b1; res_d = (ca_q < cb) ? CmpLt : CmpGt;
      end else if (LenW'(k_q) + LenW'(1) >= lmin) begin
        done_d = 1'b1;
        res_d = (la_sel == lb_sel) ? CmpEq : ((la_sel < lb_sel) ? CmpLt : CmpGt);
      end else begin
        k_d = k_q + PosW'(1);
      end
    end
    if (ctrl_i.emit_clr) e_d = '0;
    if (ctrl_i.emit_next) e_d = e_q + IdxW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; open_q <= 1'b0; ovf_q <= 1'b0;
      fl_q <= '0; ll_q <= '0;
      i_q <= '0; j_q <= '0; e_q <= '0; k_q <= '0;
      res_q <= CmpEq; done_q <= 1'b0; sel_q <= 1'b0; phase_q <= 1'b0;
      pr_q <= 1'b0; pb_q <= 1'b0; mr_q <= 1'b0; mb_q <= 1'b0;
    end else begin
      count_q <= count_d; open_q <= open_d; ovf_q <= ovf_d;
      fl_q <= fl_d; ll_q <= ll_d;
      i_q <= i_d; j_q <= j_d; e_q <= e_d; k_q <= k_d;
      res_q <= res_d; done_q <= done_d;
      if (ctrl_i.cmp_clr) sel_q <= ctrl_i.cmp_sel;
      // each read command toggles a/b phase; it returns to a after two
      if (ctrl_i.rd_pair || ctrl_i.rd_meta || ctrl_i.rd_byte) phase_q <= ~phase_q;
      else phase_q <= 1'b0;
      pr_q <= ctrl_i.rd_pair && !phase_q;
      pb_q <= ctrl_i.rd_pair && phase_q;
      mr_q <= ctrl_i.rd_meta && !phase_q;
      mb_q <= ctrl_i.rd_meta && phase_q;
    end
  end

  // captured operands
  always_ff @(posedge clk_i) begin
    if (pr_q) a_q <= ord_rd;
    if (pb_q) b_q <= ord_rd;
    if (mr_q) begin
      age_a_q <= age_rd; fa_q <= fln_rd; lla_q <= lln_rd;
    end
    if (mb_q) begin
      fb_q <= fln_rd; llb_q <= lln_rd;
    end
    if (ctrl_i.cmp_step && phase_q) ca_q <= cb;
  end

  // length pair for the selected name
  assign la_q = sel_q ? fa_q : lla_q;
  assign lb_q = sel_q ? fb_q : llb_q;

  logic ages_eq_q, age_swap_q;
  always_ff @(posedge clk_i) begin
    if (mb_q) begin
      ages_eq_q <= age_a_q == age_rd;
      age_swap_q <= age_a_q < age_rd;
    end
  end

  assign stat_o.empty     = count_q == '0;
  assign stat_o.one_left  = count_q == CntW'(1);
  assign stat_o.pair_done = CntW'(j_q) + CntW'(1) >= count_q &&
                            CntW'(i_q) + CntW'(2) >= count_q;
  assign stat_o.ages_eq   = ages_eq_q;
  assign stat_o.age_swap  = age_swap_q;
  assign stat_o.cmp_done  = done_q;
  assign stat_o.cmp_res   = res_q;
  assign stat_o.emit_last = CntW'(e_q) + CntW'(1) == count_q;

  assign record_index_o = 6'(ord_rd);
  assign record_age_o   = age_rd;
  assign overflowed_o   = ovf_q;
endmodule

/* rtl/mkres_ctrl.sv */
`timescale 1ns / 1ps
module mkres_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       criterion_i,
  input  logic             in_valid_i,
  input  logic [1:0]       op_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             no_records_o,
  output logic             last_o,
  output logic             cap_o,        // load result register this cycle
  output mkres_pkg::ctrl_t ctrl_o,
  input  mkres_pkg::stat_t stat_i
);
  import mkres_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RP0, S_RP1, S_RP2, S_RM0, S_RM1, S_RM2, S_DEC,
    S_CLR, S_B0, S_B1, S_B2, S_BW, S_RES, S_SW, S_NEXT,
    S_E0, S_E1, S_E2, S_OUT, S_SWJ
  } state_e;

  state_e state_q;
  logic   sel_q;        // name under compare: 0 last, 1 first
  logic   stage_q;      // criterion 3: 0 last-name stage, 1 first-name stage
  logic   ovalid_q, nrec_q, last_q;

  logic accept;
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = state_q == S_IDLE && !ovalid_q;

  always_comb begin
    ctrl_o = '0;
    ctrl_o.load = accept;
    ctrl_o.cmp_sel = sel_q;
    cap_o = 1'b0;
    unique case (state_q)
      S_RP0, S_RP1: ctrl_o.rd_pair = 1'b1;
      S_RM0, S_RM1: ctrl_o.rd_meta = 1'b1;
      S_CLR:        ctrl_o.cmp_clr = 1'b1;
      S_B0:         ctrl_o.rd_byte = 1'b1;
      S_B1:         begin ctrl_o.rd_byte = 1'b1; ctrl_o.cmp_step = 1'b1; end
      S_B2:         ctrl_o.cmp_step = 1'b1;
      S_SW:         ctrl_o.swap_wr_i = 1'b1;
      S_SWJ:        ctrl_o.swap_wr_j = 1'b1;
      S_NEXT:       ctrl_o.next_j = 1'b1;
      S_E0:         ctrl_o.emit_rd = 1'b1;
      S_E1:         ctrl_o.emit_age = 1'b1;
      default: ;
    endcase
    if (state_q == S_IDLE && accept && op_i == OpSort) begin
      ctrl_o.set_ij = 1'b1; ctrl_o.emit_clr = 1'b1;
    end
    if (state_q == S_E2) cap_o = 1'b1;
    // word taken: move to the next sorted place
    if (state_q == S_OUT && out_ready_i) ctrl_o.emit_next = 1'b1;
  end

  // byte reads: S_B0 issues a, S_B1 issues b and grabs a, S_B2 compares b
  logic swap_now;
  always_comb begin
    swap_now = 1'b0;
    unique case (criterion_i)
      CritLast:  swap_now = stat_i.cmp_res == CmpGt;
      CritFirst: swap_now = stat_i.cmp_res == CmpLt;
      default:   swap_now = stage_q ? stat_i.cmp_res == CmpLt : stat_i.cmp_res == CmpGt;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; sel_q <= 1'b0; stage_q <= 1'b0;
      ovalid_q <= 1'b0; nrec_q <= 1'b0; last_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept && op_i == OpSort) begin
            if (stat_i.empty) begin
              ovalid_q <= 1'b1; nrec_q <= 1'b1; last_q <= 1'b1; state_q <= S_OUT;
            end else if (stat_i.one_left || criterion_i == CritNone) begin
              state_q <= S_E0;
            end else begin
              state_q <= S_RP0;
            end
          end
        end
        S_RP0: state_q <= S_RP1;
        S_RP1: state_q <= S_RP2;
        S_RP2: state_q <= S_RM0;
        S_RM0: state_q <= S_RM1;
        S_RM1: state_q <= S_RM2;
        S_RM2: state_q <= S_DEC;
        S_DEC: begin
          stage_q <= 1'b0;
          if (criterion_i == CritAge && !stat_i.ages_eq) begin
            state_q <= stat_i.age_swap ? S_SW : S_NEXT;
          end else begin
            sel_q <= criterion_i == CritFirst;
            state_q <= S_CLR;
          end
        end
        S_CLR: state_q <= S_BW;
        S_BW:  state_q <= stat_i.cmp_done ? S_RES : S_B0;
        S_B0:  state_q <= S_B1;
        S_B1:  state_q <= S_B2;
        S_B2:  state_q <= S_BW;
        S_RES: begin
          if (criterion_i == CritAge && !stage_q && stat_i.cmp_res == CmpEq) begin
            stage_q <= 1'b1; sel_q <= 1'b1; state_q <= S_CLR;
          end else begin
            state_q <= swap_now ? S_SW : S_NEXT;
          end
        end
        S_SW:  state_q <= S_SWJ;
        S_SWJ: state_q <= S_NEXT;
        S_NEXT: state_q <= stat_i.pair_done ? S_E0 : S_RP0;
        S_E0:  state_q <= S_E1;
        S_E1:  state_q <= S_E2;
        S_E2: begin
          ovalid_q <= 1'b1; nrec_q <= 1'b0; last_q <= stat_i.emit_last;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q <= (last_q) ? S_IDLE : S_E0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = ovalid_q;
  assign no_records_o = nrec_q;
  assign last_o       = last_q;
endmodule

/* rtl/multi_key_record_exchange_sort.sv */
`timescale 1ns / 1ps
// Record sorter. Load words (op 0 start record with age, op 1/2 append a
// first/last name byte) are taken one per cycle. An op 3 word runs an i<j
// exchange sort over the loaded records under the criterion register, then
// streams one word per record (load index, age, flags, tlast on the final).
// Each pair reads its two order entries, then their ages and lengths; it is
// decided by age under criterion 3 or by a byte-wise name compare, and under
// criterion 3 a last-name tie goes on to a first-name compare; a swap writes
// both order entries. All of it is bound by the single read port of the name
// and table memories. Emitting reads each entry and age and waits for the
// receiver; a sort with no records gives its one word the cycle after it is
// taken. No load word is taken while a sort runs or a word waits.
module multi_key_record_exchange_sort (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // name_byte[7:0], age[15:8]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // record_index[5:0], record_age[13:6], zero pad
  output logic [1:0]  m_axis_tuser,   // no_records[0], overflowed[1]
  output logic        m_axis_tlast    // last
);
  import mkres_pkg::*;

  logic [1:0] crit_q;
  ctrl_t ctrl;
  stat_t stat;
  logic cap;
  logic [5:0] idx, idx_q;
  logic [7:0] age, age_q;
  logic ovf, nrec;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) crit_q <= CritNone;
    else if (cfg_valid_i) crit_q <= cfg_data_i;
  end

  mkres_ctrl u_ctrl (
    .clk_i, .rst_ni, .criterion_i(crit_q),
    .in_valid_i(s_axis_tvalid), .op_i(s_axis_tuser), .in_ready_o(s_axis_tready),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .no_records_o(nrec), .last_o(m_axis_tlast), .cap_o(cap),
    .ctrl_o(ctrl), .stat_i(stat));

  mkres_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .op_i(s_axis_tuser), .name_byte_i(s_axis_tdata[7:0]), .age_i(s_axis_tdata[15:8]),
    .record_index_o(idx), .record_age_o(age), .overflowed_o(ovf));

  // hold the emitted record while it waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; age_q <= '0;
    end else if (cap) begin
      idx_q <= idx; age_q <= age;
    end else if (s_axis_tvalid && s_axis_tready) begin
      idx_q <= '0; age_q <= '0;
    end
  end

  assign m_axis_tdata = {2'b00, age_q, idx_q};
  assign m_axis_tuser = {ovf, nrec};

`ifndef SYNTHESIS
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during emit");
  a_nrec_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast) else $error("empty not last");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("data moved");
`endif
endmodule

/* tb/sv/tb_multi_key_record_exchange_sort.sv */
`timescale 1ns / 1ps
module tb_multi_key_record_exchange_sort;
  import mkres_pkg::*;

  localparam int CycleLimit = 20000000;

  typedef struct packed {
    logic [5:0] idx;
    logic [7:0] age;
    logic       none;
    logic       ovf;
    logic       last;
  } sorted_word_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] nb;
    logic [7:0] age;
    logic       chk;      // typed-in expectation present
    sorted_word_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  multi_key_record_exchange_sort u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow state of the sorter
  logic [7:0] first_nm [MaxRecords][NameBytes];
  logic [7:0] last_nm  [MaxRecords][NameBytes];
  int         first_len [MaxRecords];
  int         last_len  [MaxRecords];
  logic [7:0] rec_age   [MaxRecords];
  int         order_q   [MaxRecords];
  int         rec_cnt;
  bit         ovf_seen;
  bit         rec_open;
  logic [1:0] sort_crit;

  sorted_word_t sorted_q[$];
  int  errors;
  int  send_idle, recv_idle;
  bit  recv_hold;
  longint cycles;

  function automatic int cmp_name(bit use_first, int a, int b);
    int la, lb, n;
    logic [7:0] ca, cb;
    la = use_first ? first_len[a] : last_len[a];
    lb = use_first ? first_len[b] : last_len[b];
    n = (la < lb) ? la : lb;
    for (int k = 0; k < n; k++) begin
      ca = use_first ? first_nm[a][k] : last_nm[a][k];
      cb = use_first ? first_nm[b][k] : last_nm[b][k];
      if (ca != cb) return (ca < cb) ? -1 : 1;
    end
    if (la == lb) return 0;
    return (la < lb) ? -1 : 1;
  endfunction

  function automatic bit must_swap(int a, int b);
    int c;
    case (sort_crit)
      CritLast: return cmp_name(1'b0, a, b) > 0;
      CritFirst: return cmp_name(1'b1, a, b) < 0;
      CritAge: begin
        if (rec_age[a] != rec_age[b]) return rec_age[a] < rec_age[b];
        c = cmp_name(1'b0, a, b);
        if (c != 0) return c > 0;
        return cmp_name(1'b1, a, b) < 0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic add_name_byte(bit use_first, logic [7:0] nb);
    int r;
    if (nb == 8'd0) return;
    if (!rec_open || rec_cnt == 0) begin
      ovf_seen = 1'b1;
      return;
    end
    r = rec_cnt - 1;
    if (use_first) begin
      if (first_len[r] >= NameBytes) ovf_seen = 1'b1;
      else begin
        first_nm[r][first_len[r]] = nb;
        first_len[r]++;
      end
    end else begin
      if (last_len[r] >= NameBytes) ovf_seen = 1'b1;
      else begin
        last_nm[r][last_len[r]] = nb;
        last_len[r]++;
      end
    end
  endtask

  // predict one accepted word
  task automatic predict_sorter(logic [1:0] op, logic [7:0] nb, logic [7:0] age);
    sorted_word_t w;
    int t;
    case (op)
      OpStart: begin
        if (rec_cnt >= MaxRecords) begin
          ovf_seen = 1'b1;
          rec_open = 1'b0;
        end else begin
          rec_age[rec_cnt] = age;
          first_len[rec_cnt] = 0;
          last_len[rec_cnt] = 0;
          order_q[rec_cnt] = rec_cnt;
          rec_cnt++;
          rec_open = 1'b1;
        end
      end
      OpFirst: add_name_byte(1'b1, nb);
      OpLast: add_name_byte(1'b0, nb);
      default: begin
        if (rec_cnt == 0) begin
          w = '{idx: '0, age: '0, none: 1'b1, ovf: ovf_seen, last: 1'b1};
          sorted_q.push_back(w);
        end else begin
          for (int i = 0; i < rec_cnt; i++)
            for (int j = i + 1; j < rec_cnt; j++)
              if (must_swap(order_q[i], order_q[j])) begin
                t = order_q[i];
                order_q[i] = order_q[j];
                order_q[j] = t;
              end
          for (int i = 0; i < rec_cnt; i++) begin
            w.idx = order_q[i][5:0];
            w.age = rec_age[order_q[i]];
            w.none = 1'b0;
            w.ovf = ovf_seen;
            w.last = (i + 1 == rec_cnt);
            sorted_q.push_back(w);
          end
        end
      end
    endcase
  endtask

  // result checker
  always @(posedge clk_i) begin
    sorted_word_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{idx: m_axis_tdata[5:0], age: m_axis_tdata[13:6], none: m_axis_tuser[0],
              ovf: m_axis_tuser[1], last: m_axis_tlast};
      if (sorted_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word idx=%0d age=%0d", $time, got.idx, got.age);
      end else begin
        want = sorted_q.pop_front();
        if (got !== want || m_axis_tdata[15:14] !== 2'b00) begin
          errors++;
          $display("%0t: mismatch exp idx=%0d age=%0d none=%b ovf=%b last=%b",
                   $time, want.idx, want.age, want.none, want.ovf, want.last);
          $display("%0t:          got idx=%0d age=%0d none=%b ovf=%b last=%b pad=%b",
                   $time, got.idx, got.age, got.none, got.ovf, got.last,
                   m_axis_tdata[15:14]);
        end
      end
    end
  end

  // receiver ready
  always @(negedge clk_i) begin
    if (recv_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_multi_key_record_exchange_sort: errors");
      $finish;
    end
  end

  // valid stays up after the word so the next one can follow back to back
  task automatic send_word(logic [1:0] op, logic [7:0] nb, logic [7:0] age);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {age, nb};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_sorter(op, nb, age);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sorted_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_crit(logic [1:0] c);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= c;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sort_crit = c;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_name(bit use_first, int n);
    for (int k = 0; k < n; k++)
      send_word(use_first ? OpFirst : OpLast, 8'($urandom_range(4) + 65), 8'($urandom));
  endtask

  stim_row_t dir_rows[$];
  sorted_word_t empty_w;
  int sends;

  initial begin
    errors = 0;
    cycles = 0;
    rec_cnt = 0;
    ovf_seen = 0;
    rec_open = 0;
    sort_crit = CritNone;
    recv_hold = 0;
    send_idle = 19;
    recv_idle = 78;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table; only the empty sort has a typed-in answer
    empty_w = '{idx: '0, age: '0, none: 1'b1, ovf: 1'b0, last: 1'b1};
    dir_rows = '{
      '{OpSort, 8'h00, 8'h00, 1'b1, empty_w},
      '{OpFirst, 8'h00, 8'h00, 1'b0, '0},   // zero byte ignored
      '{OpStart, 8'hff, 8'hff, 1'b0, '0},
      '{OpFirst, 8'hff, 8'h00, 1'b0, '0},
      '{OpLast, 8'h01, 8'hff, 1'b0, '0},
      '{OpStart, 8'h00, 8'h00, 1'b0, '0},
      '{OpFirst, 8'h01, 8'h00, 1'b0, '0},
      '{OpLast, 8'hff, 8'h00, 1'b0, '0},
      '{OpLast, 8'h00, 8'h00, 1'b0, '0},
      '{OpStart, 8'h00, 8'h80, 1'b0, '0},
      '{OpLast, 8'h01, 8'h00, 1'b0, '0},    // last name equal to the first record's
      '{OpSort, 8'h00, 8'h00, 1'b0, '0}
    };
    for (int c = 0; c < 4; c++) begin
      write_crit(c[1:0]);
      foreach (dir_rows[r]) begin
        if (c != 0 && r < 2) continue;
        if (c != 0 && dir_rows[r].op != OpSort) continue;
        if (dir_rows[r].chk) begin
          send_word(dir_rows[r].op, dir_rows[r].nb, dir_rows[r].age);
          if (sorted_q.size() == 0 || sorted_q[$] !== dir_rows[r].want) begin
            errors++;
            $display("%0t: table row %0d prediction differs from typed value", $time, r);
          end
        end else send_word(dir_rows[r].op, dir_rows[r].nb, dir_rows[r].age);
      end
    end
    drain_results();

    // random part: three idling phases, mostly well-formed records
    sends = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 19 : (ph == 1) ? 78 : 0;
      recv_idle = (ph == 0) ? 78 : (ph == 1) ? 19 : 0;
      while (sends < 115 * (ph + 1)) begin
        if ($urandom_range(9) < 8) begin
          send_word(OpStart, 8'($urandom), ($urandom_range(3) == 0) ? 8'($urandom) :
                    8'($urandom_range(3) + 20));
          send_name(1'b1, $urandom_range(3));
          send_name(1'b0, $urandom_range(3));
          sends += 3;
        end else begin
          send_word(2'($urandom), 8'($urandom), 8'($urandom));
          sends++;
        end
        if ($urandom_range(5) == 0) begin
          if ($urandom_range(3) == 0) write_crit(2'($urandom));
          send_word(OpSort, 8'($urandom), 8'($urandom));
          sends++;
        end
      end
      write_crit(2'($urandom));
    end

    // fill past capacity and send a name byte with no open record
    repeat (MaxRecords + 1 - rec_cnt) send_word(OpStart, 8'h00, 8'($urandom));
    send_word(OpFirst, 8'h41, 8'h00);
    write_crit(CritAge);
    send_word(OpSort, 8'h00, 8'h00);
    drain_results();
    send_word(OpFirst, 8'h41, 8'h00);  // record closed: dropped
    write_crit(CritLast);

    // long receiver hold while sender keeps offering
    fork
      begin
        recv_hold = 1'b1;
        while (!m_axis_tvalid) @(negedge clk_i);
        repeat (3000) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      begin
        send_word(OpSort, 8'h00, 8'h00);
        send_word(OpLast, 8'h42, 8'h00);
        send_word(OpSort, 8'h00, 8'h00);
      end
    join

    drain_results();
    if (errors == 0) begin
      $display("tb_multi_key_record_exchange_sort: clean");
    end else begin
      $display("tb_multi_key_record_exchange_sort: errors");
    end
    $finish;
  end
endmodule
